// ===== rtl/fbf_pkg.sv =====
// Shared types, codes and helper functions for the MPEG video frame boundary finder.
`timescale 1ns / 1ps

package fbf_pkg;

    // Default width of the running stream byte offset.
    localparam int POS_WIDTH_DEF = 32;

    // Fixed field widths of the result item, and the width of the zero run counter.
    localparam int BOUNDARY_POS_W = 32;
    localparam int CODE_KIND_W    = 3;
    localparam int SKIP_BYTES_W   = 3;
    localparam int ZERO_RUN_W     = 2;

    // Operation codes of an input item.
    localparam logic OP_BYTE   = 1'b0;
    localparam logic OP_RESYNC = 1'b1;

    // Start code bytes that the classifier looks for.
    localparam logic [7:0] CODE_SEQ_HDR   = 8'hB3;
    localparam logic [7:0] CODE_GOP_HDR   = 8'hB8;
    localparam logic [7:0] CODE_PIC_HDR   = 8'h00;
    localparam logic [7:0] CODE_SLICE_LO  = 8'h01;
    localparam logic [7:0] CODE_SLICE_HI  = 8'hAF;
    localparam logic [7:0] CODE_SEQ_END   = 8'hB7;
    localparam logic [7:0] PREFIX_ONE     = 8'h01;
    localparam logic [7:0] ZERO_BYTE      = 8'h00;

    // Zero run saturates once a full pair of leading zeros has been seen.
    localparam logic [ZERO_RUN_W-1:0] ZERO_RUN_MAX = 2'd2;

    // Skip count reported alongside every boundary.
    localparam logic [SKIP_BYTES_W-1:0] SKIP_ON_BOUNDARY = 3'd4;

    typedef enum logic [CODE_KIND_W-1:0] {
        KIND_NONE  = 3'd0,
        KIND_SEQ   = 3'd1,
        KIND_GOP   = 3'd2,
        KIND_PIC   = 3'd3,
        KIND_SLICE = 3'd4,
        KIND_END   = 3'd5,
        KIND_OTHER = 3'd6
    } t_code_kind;

    // Sync ranks above every other level; encodings 5..7 never arise.
    typedef enum logic [2:0] {
        ST_SYNC  = 3'd0,
        ST_SEQ   = 3'd1,
        ST_GOP   = 3'd2,
        ST_PIC   = 3'd3,
        ST_SLICE = 3'd4
    } t_sync_state;

    typedef struct packed {
        logic                      boundary;
        logic [BOUNDARY_POS_W-1:0] boundary_pos;
        t_code_kind                code_kind;
        logic [SKIP_BYTES_W-1:0]   skip_bytes;
    } t_result;

    function automatic t_code_kind classify(input logic [7:0] b);
        t_code_kind k;
        case (b) inside
            CODE_SEQ_HDR:                   k = KIND_SEQ;
            CODE_GOP_HDR:                   k = KIND_GOP;
            CODE_PIC_HDR:                   k = KIND_PIC;
            [CODE_SLICE_LO:CODE_SLICE_HI]:  k = KIND_SLICE;
            CODE_SEQ_END:                   k = KIND_END;
            default:                        k = KIND_OTHER;
        endcase
        return k;
    endfunction

    function automatic t_sync_state kind_to_state(input t_code_kind k);
        t_sync_state s;
        case (k)
            KIND_SEQ:   s = ST_SEQ;
            KIND_GOP:   s = ST_GOP;
            KIND_PIC:   s = ST_PIC;
            KIND_SLICE: s = ST_SLICE;
            default:    s = ST_SYNC;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/fbf_scan.sv =====
// Per-byte start code scanner: next scan state and the result item for one input item.
`timescale 1ns / 1ps

module fbf_scan #(
    parameter int POS_WIDTH = fbf_pkg::POS_WIDTH_DEF
) (
    input  logic                                i_operation,
    input  logic [7:0]                          i_byte_value,
    input  logic [fbf_pkg::ZERO_RUN_W-1:0]      i_zero_run,
    input  logic                                i_prefix_found,
    input  fbf_pkg::t_sync_state                i_sync_state,
    input  logic [POS_WIDTH-1:0]                i_byte_pos,
    output logic [fbf_pkg::ZERO_RUN_W-1:0]      o_zero_run,
    output logic                                o_prefix_found,
    output fbf_pkg::t_sync_state                o_sync_state,
    output logic [POS_WIDTH-1:0]                o_byte_pos,
    output fbf_pkg::t_result                    o_result
);
    import fbf_pkg::*;

    t_code_kind             w_kind;
    logic                   w_cur_sync;
    logic                   w_ranks_below;
    logic                   w_boundary;
    logic [POS_WIDTH-1:0]   w_pos_after;
    logic [POS_WIDTH-1:0]   w_pos_prefix;
    logic [POS_WIDTH-1:0]   w_pos_sel;
    logic [BOUNDARY_POS_W-1:0] w_pos_out;

    assign w_pos_after  = i_byte_pos + POS_WIDTH'(1);
    assign w_pos_prefix = i_byte_pos - POS_WIDTH'(3);

    // Unused encodings count as sync.
    assign w_cur_sync = (i_sync_state == ST_SYNC) || (i_sync_state > ST_SLICE);
    assign w_ranks_below = w_cur_sync
                           || (classify(i_byte_value) < t_code_kind'(i_sync_state));

    always_comb begin
        o_zero_run     = i_zero_run;
        o_prefix_found = i_prefix_found;
        o_sync_state   = i_sync_state;
        o_byte_pos     = i_byte_pos;
        w_kind         = KIND_NONE;
        w_boundary     = 1'b0;
        w_pos_sel      = w_pos_prefix;
        if (i_operation == OP_RESYNC) begin
            o_sync_state   = ST_SYNC;
            o_zero_run     = '0;
            o_prefix_found = 1'b0;
        end else begin
            if (i_prefix_found) begin
                o_prefix_found = 1'b0;
                o_zero_run     = '0;
                w_kind         = classify(i_byte_value);
                if (w_kind == KIND_END) begin
                    w_boundary = 1'b1;
                    w_pos_sel  = w_pos_after;
                end else if (w_kind != KIND_OTHER) begin
                    if (((w_kind == KIND_SEQ || w_kind == KIND_GOP || w_kind == KIND_PIC)
                            && w_ranks_below)
                        || (w_cur_sync && (w_kind == KIND_PIC || w_kind == KIND_SLICE))) begin
                        w_boundary = 1'b1;
                    end
                    o_sync_state = kind_to_state(w_kind);
                end
            end else if (i_byte_value == ZERO_BYTE) begin
                if (i_zero_run < ZERO_RUN_MAX) begin
                    o_zero_run = i_zero_run + ZERO_RUN_W'(1);
                end
            end else if (i_byte_value == PREFIX_ONE && i_zero_run == ZERO_RUN_MAX) begin
                o_prefix_found = 1'b1;
                o_zero_run     = '0;
            end else begin
                o_zero_run = '0;
            end
            o_byte_pos = w_pos_after;
        end
    end

    generate
        if (POS_WIDTH >= BOUNDARY_POS_W) begin : g_pos_trunc
            assign w_pos_out = w_pos_sel[BOUNDARY_POS_W-1:0];
        end else begin : g_pos_ext
            assign w_pos_out = {{(BOUNDARY_POS_W-POS_WIDTH){1'b0}}, w_pos_sel};
        end
    endgenerate

    always_comb begin
        o_result.boundary     = w_boundary;
        o_result.boundary_pos = w_boundary ? w_pos_out : '0;
        o_result.code_kind    = w_kind;
        o_result.skip_bytes   = w_boundary ? SKIP_ON_BOUNDARY : '0;
    end

endmodule

// ===== rtl/fbf_out_reg.sv =====
// Result register with valid/ready handshake toward the consumer.
`timescale 1ns / 1ps

module fbf_out_reg (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_load,
    input  fbf_pkg::t_result                        i_result,
    input  logic                                    i_ready,
    output logic                                    o_can_load,
    output logic                                    o_valid,
    output logic                                    o_boundary,
    output logic [fbf_pkg::BOUNDARY_POS_W-1:0]      o_boundary_pos,
    output logic [fbf_pkg::CODE_KIND_W-1:0]         o_code_kind,
    output logic [fbf_pkg::SKIP_BYTES_W-1:0]        o_skip_bytes
);
    import fbf_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    // A new result may enter when the slot is empty or is being emptied now.
    assign o_can_load = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid        = r_valid;
    assign o_boundary     = r_result.boundary;
    assign o_boundary_pos = r_result.boundary_pos;
    assign o_code_kind    = r_result.code_kind;
    assign o_skip_bytes   = r_result.skip_bytes;

endmodule

// ===== rtl/mpeg_video_frame_boundary_finder.sv =====
// Top level of the MPEG-1/2 video frame boundary finder.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake           Payload
//  input     in         i_valid / o_ready   i_operation, i_byte_value
//  result    out        o_valid / i_ready   o_boundary, o_boundary_pos, o_code_kind,
//                                           o_skip_bytes
//
// One item is accepted per cycle while o_ready is high; its result appears in the output
// register on the next cycle, so throughput is one item per clock.
// The scan state (zero run, prefix flag, sync level, byte offset) updates on the same
// edge that accepts the item. Synchronous active-low reset clears the scan state and
// empties the output register. When the consumer holds i_ready low with a result
// waiting, o_ready drops and the input stalls; otherwise input flows every cycle.

module mpeg_video_frame_boundary_finder #(
    parameter int POS_WIDTH = fbf_pkg::POS_WIDTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic                                    i_operation,
    input  logic [7:0]                              i_byte_value,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic                                    o_boundary,
    output logic [fbf_pkg::BOUNDARY_POS_W-1:0]      o_boundary_pos,
    output logic [fbf_pkg::CODE_KIND_W-1:0]         o_code_kind,
    output logic [fbf_pkg::SKIP_BYTES_W-1:0]        o_skip_bytes
);
    import fbf_pkg::*;

    // Scan state carried from one stream byte to the next.
    logic [ZERO_RUN_W-1:0] r_zero_run;
    logic [ZERO_RUN_W-1:0] n_zero_run;
    logic                  r_prefix_found;
    logic                  n_prefix_found;
    t_sync_state           r_sync_state;
    t_sync_state           n_sync_state;
    logic [POS_WIDTH-1:0]  r_byte_pos;
    logic [POS_WIDTH-1:0]  n_byte_pos;

    t_result               w_result;
    logic                  w_can_load;
    logic                  w_accept;

    assign o_ready  = w_can_load;
    assign w_accept = i_valid && w_can_load;

    // The scanner decides everything for the accepted item in one pass: it tracks the
    // zero run toward a 00 00 01 prefix, classifies the code byte after a prefix, and
    // compares the code against the current sync level to flag a frame boundary.
    fbf_scan #(
        .POS_WIDTH (POS_WIDTH)
    ) u_scan (
        .i_operation    (i_operation),
        .i_byte_value   (i_byte_value),
        .i_zero_run     (r_zero_run),
        .i_prefix_found (r_prefix_found),
        .i_sync_state   (r_sync_state),
        .i_byte_pos     (r_byte_pos),
        .o_zero_run     (n_zero_run),
        .o_prefix_found (n_prefix_found),
        .o_sync_state   (n_sync_state),
        .o_byte_pos     (n_byte_pos),
        .o_result       (w_result)
    );

    // State only moves on an accepted item, so stalls never disturb the scan.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_run     <= '0;
            r_prefix_found <= 1'b0;
            r_sync_state   <= ST_SYNC;
            r_byte_pos     <= '0;
        end else if (w_accept) begin
            r_zero_run     <= n_zero_run;
            r_prefix_found <= n_prefix_found;
            r_sync_state   <= n_sync_state;
            r_byte_pos     <= n_byte_pos;
        end
    end

    // Every accepted item yields exactly one result item.
    fbf_out_reg u_out_reg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (w_accept),
        .i_result       (w_result),
        .i_ready        (i_ready),
        .o_can_load     (w_can_load),
        .o_valid        (o_valid),
        .o_boundary     (o_boundary),
        .o_boundary_pos (o_boundary_pos),
        .o_code_kind    (o_code_kind),
        .o_skip_bytes   (o_skip_bytes)
    );

endmodule
